### hdl/cnc_pkg.sv
// Shared types and constants for the cutoff neighbor counter.
// Used by every module in the block; depends on nothing else.
package cnc_pkg;

    // Fixed field widths of the item and result ports.
    localparam int FIELD_W   = 20;
    localparam int PRIOR_W   = 6;
    localparam int INDEX_W   = 6;
    localparam int COUNT_W   = 7;

    // Configuration register file.
    localparam int CUTOFF_W  = 44;
    localparam int DATA_W    = 64;
    localparam int PADDR_W   = 4;
    localparam int REG_SEL_W = 1;
    localparam logic [REG_SEL_W-1:0] REG_CUTOFF = 1'b0;
    // floor((1.6 * 256)^2) in (1/256 angstrom) squared.
    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 44'd167772;

    // Parameter defaults.
    localparam int MAX_ATOMS_DEF  = 64;
    localparam int COORD_BITS_DEF = 20;

    // Control from the sequencer to the distance pipeline.
    typedef struct packed {
        logic load_a;   // read data holds the reference atom
        logic sample;   // read data holds a candidate neighbor
    } pipe_ctrl_t;

endpackage

### hdl/cnc_cfg_regs.sv
// APB-style register file holding the squared cutoff distance.
// Depends on cnc_pkg for widths, register index and reset value.
module cnc_cfg_regs
    import cnc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    output logic [CUTOFF_W-1:0] cutoff_sq
);

    logic [CUTOFF_W-1:0]  cutoff_reg;
    logic [REG_SEL_W-1:0] reg_sel;

    // Registers sit on 8-byte boundaries.
    assign reg_sel = paddr[PADDR_W-1:3];
    assign pready  = 1'b1;

    // Write on the access phase of a write transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= CUTOFF_RESET;
        end
        else if (psel && penable && pwrite && (reg_sel == REG_CUTOFF))
        begin
            cutoff_reg <= pwdata[CUTOFF_W-1:0];
        end
    end

    // Read back.
    always_comb
    begin
        prdata = '0;
        if (reg_sel == REG_CUTOFF)
        begin
            prdata = DATA_W'(cutoff_reg);
        end
    end

    assign cutoff_sq = cutoff_reg;

endmodule

### hdl/cnc_atom_ram.sv
// Atom store: one write port and one registered read port.
// Each word packs the x, y, z coordinates and the prior bond count.
module cnc_atom_ram
    import cnc_pkg::*;
#(
    parameter int MAX_ATOMS  = MAX_ATOMS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int AW        = $clog2(MAX_ATOMS),
    localparam int WORD_W    = 3 * COORD_BITS + PRIOR_W
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [MAX_ATOMS];
    logic [WORD_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/cnc_dist_pipe.sv
// Two-stage squared-distance pipeline and neighbor accumulator.
// Depends on cnc_pkg; fed by the atom store read port.
module cnc_dist_pipe
    import cnc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int WORD_W    = 3 * COORD_BITS + PRIOR_W,
    localparam int SQ_W      = 2 * COORD_BITS + 1,
    localparam int SUM_W     = SQ_W + 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  pipe_ctrl_t          ctrl,
    input  logic [WORD_W-1:0]   rdata,
    input  logic [CUTOFF_W-1:0] cutoff_sq,
    output logic [COUNT_W-1:0]  acc,
    output logic                busy
);

    localparam int C = COORD_BITS;

    logic [3*C-1:0]        ref_reg;
    logic [COUNT_W-1:0]    acc_reg;
    logic                  sq_valid_reg;
    logic [SQ_W-1:0]       sqx_reg;
    logic [SQ_W-1:0]       sqy_reg;
    logic [SQ_W-1:0]       sqz_reg;

    logic [C-1:0]          ax, ay, az, bx, by, bz;
    logic signed [C:0]     dx, dy, dz;
    logic signed [2*C+1:0] px, py, pz;
    logic [SUM_W-1:0]      d2;
    logic                  hit;

    // Unpack the reference atom and the candidate.
    assign ax = ref_reg[3*C-1:2*C];
    assign ay = ref_reg[2*C-1:C];
    assign az = ref_reg[C-1:0];
    assign bx = rdata[WORD_W-1:WORD_W-C];
    assign by = rdata[WORD_W-C-1:WORD_W-2*C];
    assign bz = rdata[WORD_W-2*C-1:PRIOR_W];

    // Stage one: exact differences and their squares.
    assign dx = $signed({ax[C-1], ax}) - $signed({bx[C-1], bx});
    assign dy = $signed({ay[C-1], ay}) - $signed({by[C-1], by});
    assign dz = $signed({az[C-1], az}) - $signed({bz[C-1], bz});
    assign px = dx * dx;
    assign py = dy * dy;
    assign pz = dz * dz;

    always_ff @(posedge clk)
    begin
        sqx_reg <= px[SQ_W-1:0];
        sqy_reg <= py[SQ_W-1:0];
        sqz_reg <= pz[SQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else
        begin
            sq_valid_reg <= ctrl.sample;
        end
    end

    // Stage two: sum, range check and count.
    assign d2  = SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
    assign hit = (d2 != '0) && (CUTOFF_W'(d2) <= cutoff_sq);

    // The reference atom is latched with its prior count as the start value.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_a)
        begin
            ref_reg <= rdata[WORD_W-1:PRIOR_W];
            acc_reg <= COUNT_W'(rdata[PRIOR_W-1:0]);
        end
        else if (sq_valid_reg && hit)
        begin
            acc_reg <= acc_reg + COUNT_W'(1);
        end
    end

    assign acc  = acc_reg;
    assign busy = sq_valid_reg;

endmodule

### hdl/cutoff_neighbor_counter_core.sv
// Cutoff neighbor counter: loads one residue, then counts close neighbors per atom.
// Loading takes one item per cycle. After the last atom of a residue with n stored
// atoms, each atom is scanned with one store read per pair in the scan, and the
// next item is taken only once every result of the residue has been emitted.
// Reset clears the atom count, truncation flag and sequencer and restores the
// default cutoff; the atom store itself is not cleared.
module cutoff_neighbor_counter_core
    import cnc_pkg::*;
#(
    parameter int MAX_ATOMS  = MAX_ATOMS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // APB-style configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready,
    // Atom items
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [FIELD_W-1:0]  x_coord,
    input  logic signed [FIELD_W-1:0]  y_coord,
    input  logic signed [FIELD_W-1:0]  z_coord,
    input  logic [PRIOR_W-1:0]         prior_bonds,
    input  logic                       last_atom,
    // Result items
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [INDEX_W-1:0]         atom_index,
    output logic [COUNT_W-1:0]         bond_count,
    output logic                       truncated,
    output logic                       last_result
);

    localparam int AW     = $clog2(MAX_ATOMS);
    localparam int CW     = $clog2(MAX_ATOMS + 1);
    localparam int WORD_W = 3 * COORD_BITS + PRIOR_W;

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_FETCH = 6'b000010,
        ST_LATCH = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     n_reg, n_next;
    logic              ovf_reg, ovf_next;
    logic [AW-1:0]     a_reg, a_next;
    logic [AW-1:0]     b_reg, b_next;
    logic              sample_reg;
    logic              out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] idx_reg;
    logic [COUNT_W-1:0] cnt_out_reg;
    logic              trunc_reg;
    logic              last_reg;

    logic              in_fire;
    logic              room;
    logic              we;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;
    logic [WORD_W-1:0] rdata;
    logic [CUTOFF_W-1:0] cutoff_sq;
    logic [COUNT_W-1:0] acc;
    logic              busy;
    logic              a_last;
    logic              b_last;
    pipe_ctrl_t        ctrl;

    // Configuration registers.
    cnc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cutoff_sq (cutoff_sq)
    );

    // Atom store.
    cnc_atom_ram #(
        .MAX_ATOMS  (MAX_ATOMS),
        .COORD_BITS (COORD_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Distance pipeline.
    cnc_dist_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .rdata     (rdata),
        .cutoff_sq (cutoff_sq),
        .acc       (acc),
        .busy      (busy)
    );

    // Input handshake and store write.
    assign in_stall = (state_reg != ST_LOAD);
    assign in_fire  = in_valid && !in_stall;
    assign room     = (cnt_reg < CW'(MAX_ATOMS));
    assign we       = in_fire && room;
    assign wdata    = {x_coord[COORD_BITS-1:0], y_coord[COORD_BITS-1:0],
                       z_coord[COORD_BITS-1:0], prior_bonds};

    // Store reads: the reference atom, then every stored atom in turn.
    assign re    = (state_reg == ST_FETCH) || (state_reg == ST_SCAN);
    assign raddr = (state_reg == ST_FETCH) ? a_reg : b_reg;

    assign ctrl.load_a = (state_reg == ST_LATCH);
    assign ctrl.sample = sample_reg;

    assign a_last = ((CW'(a_reg) + CW'(1)) == n_reg);
    assign b_last = ((CW'(b_reg) + CW'(1)) == n_reg);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        ovf_next       = ovf_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        out_valid_next = out_valid_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (room)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_atom)
                    begin
                        n_next     = room ? cnt_reg + CW'(1) : cnt_reg;
                        a_next     = '0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                b_next     = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (b_last)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    b_next = b_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!sample_reg && !busy)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (a_last)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        a_next     = a_reg + AW'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            n_reg         <= '0;
            ovf_reg       <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            sample_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            ovf_reg       <= ovf_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            sample_reg    <= (state_reg == ST_SCAN);
            out_valid_reg <= out_valid_next;
        end
    end

    // Result register, loaded once the scan of an atom has drained.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DRAIN) && !sample_reg && !busy)
        begin
            idx_reg     <= INDEX_W'(a_reg);
            cnt_out_reg <= acc;
            trunc_reg   <= ovf_reg;
            last_reg    <= a_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign atom_index  = idx_reg;
    assign bond_count  = cnt_out_reg;
    assign truncated   = trunc_reg;
    assign last_result = last_reg;

endmodule

### dv/cutoff_neighbor_counter_core_tb.sv
// Self-checking testbench for cutoff_neighbor_counter_core: drives residues of atoms,
// predicts the per-atom bond counts in step with the accepted items, and checks results.
// Depends on cnc_pkg and the cutoff_neighbor_counter_core RTL only.
module cutoff_neighbor_counter_core_tb
    import cnc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int IDLE_PCT      = 17;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES    = 200;
    localparam int REG_STRIDE    = 8;
    localparam int REG_SPARE     = 1;
    localparam int CAPACITY      = MAX_ATOMS_DEF;
    localparam longint TIMEOUT_NS = 64'd8_000_000;
    localparam logic [CUTOFF_W-1:0] CUTOFF_MAX = {CUTOFF_W{1'b1}};

    typedef struct packed {
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] z;
        logic [PRIOR_W-1:0]        prior;
    } atom_t;

    typedef struct packed {
        logic [INDEX_W-1:0] atom_idx;
        logic [COUNT_W-1:0] count;
        logic               trunc;
        logic               last_flag;
    } bond_result_t;

    logic                      clk;
    logic                      rst_n       = 1'b0;
    logic                      psel        = 1'b0;
    logic                      penable     = 1'b0;
    logic                      pwrite      = 1'b0;
    logic [PADDR_W-1:0]        paddr       = '0;
    logic [DATA_W-1:0]         pwdata      = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      in_valid    = 1'b0;
    logic                      in_stall;
    logic signed [FIELD_W-1:0] x_coord     = '0;
    logic signed [FIELD_W-1:0] y_coord     = '0;
    logic signed [FIELD_W-1:0] z_coord     = '0;
    logic [PRIOR_W-1:0]        prior_bonds = '0;
    logic                      last_atom   = 1'b0;
    logic                      out_valid;
    logic                      out_stall   = 1'b0;
    logic [INDEX_W-1:0]        atom_index;
    logic [COUNT_W-1:0]        bond_count;
    logic                      truncated;
    logic                      last_result;

    // Predictor state: the residue being loaded and the cutoff in force.
    atom_t               residue_atoms[$];
    bit                  residue_dropped = 1'b0;
    logic [CUTOFF_W-1:0] cutoff_limit    = CUTOFF_RESET;
    bond_result_t        bond_results_due[$];

    int error_count  = 0;
    bit idle_on      = 1'b1;
    int hold_request = 0;
    int hold_left    = 0;

    cutoff_neighbor_counter_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .z_coord     (z_coord),
        .prior_bonds (prior_bonds),
        .last_atom   (last_atom),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .atom_index  (atom_index),
        .bond_count  (bond_count),
        .truncated   (truncated),
        .last_result (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    function automatic void note_failure(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endfunction

    function automatic atom_t make_atom(int x, int y, int z, int prior);
        atom_t a;
        a.x     = x[FIELD_W-1:0];
        a.y     = y[FIELD_W-1:0];
        a.z     = z[FIELD_W-1:0];
        a.prior = prior[PRIOR_W-1:0];
        return a;
    endfunction

    function automatic logic signed [FIELD_W-1:0] random_coord();
        logic [31:0] r;
        r = $urandom();
        return r[FIELD_W-1:0];
    endfunction

    // Store an accepted atom; on the last atom, count neighbors within the cutoff
    // for every stored atom and queue one result per atom in load order.
    function automatic void record_atom(atom_t a, bit last);
        bond_result_t r;
        int           n;
        int           cnt;
        longint       dx;
        longint       dy;
        longint       dz;
        longint       d2;
        if (residue_atoms.size() < CAPACITY)
            residue_atoms.push_back(a);
        else
            residue_dropped = 1'b1;
        if (!last)
            return;
        n = residue_atoms.size();
        for (int i = 0; i < n; i++)
        begin
            cnt = residue_atoms[i].prior;
            for (int j = 0; j < n; j++)
            begin
                dx = longint'($signed(residue_atoms[i].x)) - longint'($signed(residue_atoms[j].x));
                dy = longint'($signed(residue_atoms[i].y)) - longint'($signed(residue_atoms[j].y));
                dz = longint'($signed(residue_atoms[i].z)) - longint'($signed(residue_atoms[j].z));
                d2 = dx * dx + dy * dy + dz * dz;
                // Coincident atoms, the atom itself included, never count.
                if (d2 > 0 && d2 <= longint'(cutoff_limit))
                    cnt++;
            end
            r.atom_idx  = INDEX_W'(i);
            r.count     = COUNT_W'(cnt);
            r.trunc     = residue_dropped;
            r.last_flag = (i == n - 1);
            bond_results_due.push_back(r);
        end
        residue_atoms.delete();
        residue_dropped = 1'b0;
    endfunction

    // Offer one atom, with random idle cycles ahead of it, and hold it until taken.
    task automatic send_atom(atom_t a, bit last);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        x_coord     <= a.x;
        y_coord     <= a.y;
        z_coord     <= a.z;
        prior_bonds <= a.prior;
        last_atom   <= last;
        do
            @(posedge clk);
        while (in_stall);
        record_atom(a, last);
    endtask

    // Stop offering items and wait until every expected result has come out.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (bond_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write a register while the block is idle, then read back the cutoff.
    task automatic write_reg(int idx, logic [DATA_W-1:0] value);
        wait_drained();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * REG_STRIDE);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == int'(REG_CUTOFF))
            cutoff_limit = value[CUTOFF_W-1:0];
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= PADDR_W'(int'(REG_CUTOFF) * REG_STRIDE);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== DATA_W'(cutoff_limit))
            note_failure($sformatf("cutoff readback: expected %0d actual %0d",
                                   cutoff_limit, prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One residue of n atoms: mostly a cluster around a random center, with some
    // copies of earlier positions and some atoms anywhere in the coordinate range.
    task automatic send_residue(int n);
        atom_t made[$];
        atom_t centre;
        atom_t a;
        int    spread;
        int    pick;
        int    off;
        centre = make_atom(int'(random_coord()), int'(random_coord()),
                           int'(random_coord()), 0);
        case ($urandom_range(2))
            0:       spread = 64;
            1:       spread = 600;
            default: spread = 3000;
        endcase
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (i > 0 && pick < 10)
                a = made[$urandom_range(made.size() - 1)];
            else if (pick < 25)
            begin
                a.x = random_coord();
                a.y = random_coord();
                a.z = random_coord();
            end
            else
            begin
                off = int'($urandom_range(2 * spread)) - spread;
                a.x = centre.x + off[FIELD_W-1:0];
                off = int'($urandom_range(2 * spread)) - spread;
                a.y = centre.y + off[FIELD_W-1:0];
                off = int'($urandom_range(2 * spread)) - spread;
                a.z = centre.z + off[FIELD_W-1:0];
            end
            a.prior = PRIOR_W'($urandom_range(63));
            made.push_back(a);
            send_atom(a, i == n - 1);
        end
    endtask

    // A residue of one atom gets only its prior count.
    task automatic test_single_atom();
        send_atom(make_atom(0, 0, 0, 63), 1'b1);
    endtask

    // Coincident atoms never count each other; a close atom counts for all of them.
    task automatic test_identical_positions();
        send_atom(make_atom(100, 200, -300, 5), 1'b0);
        send_atom(make_atom(100, 200, -300, 0), 1'b0);
        send_atom(make_atom(100, 200, -300, 7), 1'b0);
        send_atom(make_atom(150, 200, -300, 1), 1'b0);
        send_atom(make_atom(100000, -2000, 40, 2), 1'b1);
    endtask

    // A pair exactly at the cutoff counts; one step beyond does not.
    task automatic test_cutoff_boundary();
        write_reg(int'(REG_CUTOFF), DATA_W'(1000000));
        send_atom(make_atom(0, 0, 0, 3), 1'b0);
        send_atom(make_atom(1000, 0, 0, 0), 1'b0);
        send_atom(make_atom(0, 600, 800, 10), 1'b0);
        send_atom(make_atom(0, 0, -1001, 4), 1'b1);
    endtask

    // Corners of the coordinate range under the widest cutoff.
    task automatic test_coord_extremes();
        write_reg(int'(REG_CUTOFF), DATA_W'(CUTOFF_MAX));
        send_atom(make_atom(-524288, -524288, -524288, 63), 1'b0);
        send_atom(make_atom(524287, 524287, 524287, 63), 1'b0);
        send_atom(make_atom(0, 0, 0, 0), 1'b0);
        send_atom(make_atom(-524288, 524287, -524288, 63), 1'b0);
        send_atom(make_atom(524287, -524288, 524287, 0), 1'b1);
    endtask

    // A zero cutoff leaves only the prior counts, even for the closest pairs.
    task automatic test_zero_cutoff();
        write_reg(int'(REG_CUTOFF), '0);
        send_atom(make_atom(5, 5, 5, 12), 1'b0);
        send_atom(make_atom(6, 5, 5, 0), 1'b0);
        send_atom(make_atom(5, 5, 5, 33), 1'b1);
    endtask

    // A write to an unused register index must leave the cutoff alone.
    task automatic test_spare_register();
        write_reg(REG_SPARE, DATA_W'(CUTOFF_MAX));
        send_atom(make_atom(-7, 0, 0, 1), 1'b0);
        send_atom(make_atom(-6, 0, 0, 2), 1'b1);
    endtask

    // A full residue reaching the largest count, then one that overflows the
    // store; the dropped last atom still closes the residue.
    task automatic test_capacity_overflow();
        atom_t a;
        write_reg(int'(REG_CUTOFF), DATA_W'(CUTOFF_MAX));
        for (int i = 0; i < CAPACITY; i++)
        begin
            a = make_atom(int'(random_coord()), int'(random_coord()),
                          int'(random_coord()), 63);
            send_atom(a, i == CAPACITY - 1);
        end
        write_reg(int'(REG_CUTOFF), DATA_W'(CUTOFF_RESET));
        send_residue(CAPACITY + 3);
    endtask

    // Random residues under a series of cutoff settings.
    task automatic test_random_residues();
        logic [CUTOFF_W-1:0] value;
        int                  r;
        int                  sent;
        int                  n;
        for (int phase = 0; phase < 6; phase++)
        begin
            r = $urandom_range(3000);
            case ($urandom_range(5))
                0:       value = CUTOFF_W'(r * r);
                1:       value = CUTOFF_W'(r * r + 1);
                2:       value = CUTOFF_RESET;
                3:       value = {12'($urandom_range(4095)), 32'($urandom())};
                4:       value = '0;
                default: value = CUTOFF_MAX;
            endcase
            write_reg(int'(REG_CUTOFF), DATA_W'(value));
            sent = 0;
            while (sent < 15)
            begin
                if ($urandom_range(9) == 0)
                    n = $urandom_range(24, 11);
                else
                    n = $urandom_range(8, 1);
                send_residue(n);
                sent += n;
            end
        end
    endtask

    // The receiver holds off for a long stretch while residues keep coming, so the
    // block backs up into its input; then the sender waits for every result.
    task automatic test_backpressure();
        write_reg(int'(REG_CUTOFF), DATA_W'(600 * 600));
        hold_request = 400;
        repeat (4) send_residue(6);
        wait_drained();
        send_residue(5);
    endtask

    // A stretch with neither side idling.
    task automatic test_steady_stream();
        wait_drained();
        idle_on = 1'b0;
        repeat (4) send_residue($urandom_range(8, 3));
        wait_drained();
        idle_on = 1'b1;
    endtask

    // Receiver: random stalls, or a long hold when a test asks for one.
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end

    // Compare every accepted result with the oldest expected one.
    always @(posedge clk)
    begin : check_results
        bond_result_t got;
        bond_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{atom_index, bond_count, truncated, last_result};
            if (bond_results_due.size() == 0)
                note_failure($sformatf("unexpected result: index %0d count %0d trunc %0b last %0b",
                                       got.atom_idx, got.count, got.trunc, got.last_flag));
            else
            begin
                want = bond_results_due.pop_front();
                if (got !== want)
                    note_failure($sformatf(
                        "result mismatch: expected %0d/%0d/%0b/%0b actual %0d/%0d/%0b/%0b",
                        want.atom_idx, want.count, want.trunc, want.last_flag,
                        got.atom_idx, got.count, got.trunc, got.last_flag));
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_single_atom();
        test_identical_positions();
        test_cutoff_boundary();
        test_coord_extremes();
        test_zero_cutoff();
        test_spare_register();
        test_capacity_overflow();
        test_random_residues();
        test_backpressure();
        test_steady_stream();

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (bond_results_due.size() != 0)
            note_failure($sformatf("%0d expected results never arrived",
                                   bond_results_due.size()));
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
hdl/cnc_pkg.sv
hdl/cnc_cfg_regs.sv
hdl/cnc_atom_ram.sv
hdl/cnc_dist_pipe.sv
hdl/cutoff_neighbor_counter_core.sv
dv/cutoff_neighbor_counter_core_tb.sv
